@@ rtl/png_chunk_stream_parser_macros.svh @@
// Assertion macros for the chunk parser
`ifndef PNG_CHUNK_STREAM_PARSER_MACROS_SVH
`define PNG_CHUNK_STREAM_PARSER_MACROS_SVH

// Implication checked on every clock edge outside reset
`define PCP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent
`define PCP_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/pcsp_pkg.sv @@
package pcsp_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    EV_CHUNK    = 2'd0,
    EV_BAD_SIG  = 2'd1,
    EV_NOT_IHDR = 2'd2,
    EV_IEND     = 2'd3
  } event_kind_e;

  localparam logic [31:0] CrcPoly   = 32'hedb88320;
  localparam logic [31:0] CrcInit   = 32'hFFFFFFFF;
  localparam logic [31:0] TypeIhdr  = 32'h49484452;
  localparam logic [31:0] TypeIend  = 32'h49454E44;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [31:0] chunk_type;
    logic [30:0] chunk_length;
    logic [31:0] stored_crc;
    logic [31:0] computed_crc;
    logic [31:0] image_width;
    logic [31:0] image_height;
    logic [7:0]  sample_depth;
    logic [7:0]  colour_code;
    logic [7:0]  compression_method;
    logic [7:0]  filter_method;
    logic [7:0]  interlace_method;
  } out_item_t;

  function automatic logic [7:0] sig_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0: r = 8'd137;
      3'd1: r = 8'd80;
      3'd2: r = 8'd78;
      3'd3: r = 8'd71;
      3'd4: r = 8'd13;
      3'd5: r = 8'd10;
      3'd6: r = 8'd26;
      default: r = 8'd10;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] crc_entry(input logic [7:0] idx);
    logic [31:0] c;
    c = {24'd0, idx};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
    return (crc >> 8) ^ crc_entry(crc[7:0] ^ b);
  endfunction

endpackage

@@ rtl/pcsp_if.sv @@
interface pcsp_in_if;
  logic                     valid;
  logic                     ready;
  pcsp_pkg::in_item_t       payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface pcsp_out_if;
  logic                     valid;
  logic                     ready;
  pcsp_pkg::out_item_t      payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/png_chunk_stream_parser.sv @@
// With the queue empty and no stall, an accepted byte passes through the queue and then the result register.
// Throughput: one byte per cycle while the output is not stalled; the CRC update is combinational.
// A two-entry queue separates byte intake from parsing; results sit in one output register.
// Reset (rst_ni low, asynchronous) empties the queue and returns to the signature phase.
// start_of_file on a byte restarts parsing and clears the latched header fields.
module png_chunk_stream_parser #(
  parameter int unsigned QueueDepth = pcsp_pkg::QueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcsp_in_if.sink    in_if,
  pcsp_out_if.source out_if
);
  import pcsp_pkg::*;

  logic     push, full, q_valid, pop;
  in_item_t push_item, q_item;

  pcsp_front u_front (
    .clk_i, .rst_ni, .in_if,
    .push_o(push), .push_item_o(push_item), .full_i(full)
  );

  pcsp_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .push_i(push), .push_item_i(push_item), .full_o(full),
    .pop_valid_o(q_valid), .pop_item_o(q_item), .pop_i(pop)
  );

  pcsp_back u_back (
    .clk_i, .rst_ni,
    .item_valid_i(q_valid), .item_i(q_item), .pop_o(pop), .out_if
  );
endmodule

@@ rtl/pcsp_front.sv @@
module pcsp_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  pcsp_in_if.sink            in_if,
  output logic               push_o,
  output pcsp_pkg::in_item_t push_item_o,
  input  logic               full_i
);
  import pcsp_pkg::*;

  // Forward every byte; drop nothing, classification is by start flag.
  assign in_if.ready  = !full_i;
  assign push_o       = in_if.valid && !full_i;
  assign push_item_o  = in_if.payload;

  logic seen_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (push_o) begin
      seen_q <= 1'b1;
    end
  end

  `include "png_chunk_stream_parser_macros.svh"
  `PCP_ASSERT_IMP(a_push_ready, clk_i, rst_ni, push_o, in_if.ready, "push without ready")
  `PCP_ASSERT_NEXT(a_seen, clk_i, rst_ni, push_o, seen_q, "seen flag not set")
  `PCP_ASSERT_IMP(a_no_full_push, clk_i, rst_ni, full_i, !push_o, "push into full queue")
endmodule

@@ rtl/pcsp_queue.sv @@
module pcsp_queue #(
  parameter int unsigned Depth = pcsp_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  pcsp_pkg::in_item_t push_item_i,
  output logic               full_o,
  output logic               pop_valid_o,
  output pcsp_pkg::in_item_t pop_item_o,
  input  logic               pop_i
);
  import pcsp_pkg::*;
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  in_item_t        mem_q [Depth];
  logic [Aw-1:0]   wr_q, rd_q;
  logic [Aw:0]     cnt_q;

  assign full_o      = (cnt_q == (Aw+1)'(Depth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= push_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == Aw'(Depth-1)) ? '0 : wr_q + Aw'(1);
      if (pop_i)  rd_q <= (rd_q == Aw'(Depth-1)) ? '0 : rd_q + Aw'(1);
      cnt_q <= cnt_q + (Aw+1)'(push_i) - (Aw+1)'(pop_i);
    end
  end

  `include "png_chunk_stream_parser_macros.svh"
  `PCP_ASSERT_IMP(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= (Aw+1)'(Depth), "count overflow")
  `PCP_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, pop_i, pop_valid_o, "pop while empty")
  `PCP_ASSERT_IMP(a_push_nonfull, clk_i, rst_ni, push_i, !full_o, "push while full")
endmodule

@@ rtl/pcsp_back.sv @@
module pcsp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                item_valid_i,
  input  pcsp_pkg::in_item_t  item_i,
  output logic                pop_o,
  pcsp_out_if.source          out_if
);
  import pcsp_pkg::*;

  typedef enum logic [2:0] {
    PH_SIG, PH_LEN, PH_TYPE, PH_DATA, PH_CRC, PH_HALT
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [30:0] cnt_q, cnt_d;
  logic [30:0] len_q, len_d;
  logic [31:0] type_q, type_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] scrc_q, scrc_d;
  logic [31:0] wid_q, wid_d;
  logic [31:0] hgt_q, hgt_d;
  logic [39:0] hdr_q, hdr_d;
  logic        first_q, first_d;

  out_item_t   res_q, res_d;
  logic        res_vld_q;
  logic        emit;
  logic        can_take;
  logic [7:0]  b;
  logic [31:0] ntype;
  logic [31:0] ncrc;
  logic [31:0] nscrc;
  logic [30:0] ncnt;

  assign can_take = !res_vld_q || out_if.ready;
  assign pop_o    = item_valid_i && can_take;
  assign out_if.valid   = res_vld_q;
  assign out_if.payload = res_q;
  assign b = item_i.data_byte;

  always_comb begin
    phase_e ph;
    logic [30:0] c;
    logic [30:0] l;
    logic [31:0] t;
    logic [31:0] cr;
    logic [31:0] sc;
    logic [31:0] w;
    logic [31:0] h;
    logic [39:0] hd;
    logic        f;
    if (item_i.start_of_file) begin
      ph = PH_SIG; c = '0; l = '0; t = '0; cr = CrcInit; sc = '0;
      w = '0; h = '0; hd = '0; f = 1'b1;
    end else begin
      ph = phase_q; c = cnt_q; l = len_q; t = type_q; cr = crc_q; sc = scrc_q;
      w = wid_q; h = hgt_q; hd = hdr_q; f = first_q;
    end
    ncrc  = crc_update(cr, b);
    ntype = {t[23:0], b};
    nscrc = {sc[23:0], b};
    ncnt  = c + 31'd1;
    emit  = 1'b0;
    res_d = res_q;
    phase_d = ph; cnt_d = c; len_d = l; type_d = t; crc_d = cr; scrc_d = sc;
    wid_d = w; hgt_d = h; hdr_d = hd; first_d = f;
    unique case (ph)
      PH_SIG: begin
        if (b != sig_byte(c[2:0])) begin
          emit = 1'b1;
          res_d = '{event_kind: EV_BAD_SIG, chunk_type: '0, chunk_length: '0,
                    stored_crc: '0, computed_crc: '0, image_width: w, image_height: h,
                    sample_depth: hd[39:32], colour_code: hd[31:24],
                    compression_method: hd[23:16], filter_method: hd[15:8],
                    interlace_method: hd[7:0]};
          phase_d = PH_HALT;
        end else if (ncnt >= 31'd8) begin
          cnt_d = '0; phase_d = PH_LEN;
        end else begin
          cnt_d = ncnt;
        end
      end
      PH_LEN: begin
        len_d = {l[22:0], b};
        if (ncnt >= 31'd4) begin
          cnt_d = '0; type_d = '0; crc_d = CrcInit; phase_d = PH_TYPE;
        end else begin
          cnt_d = ncnt;
        end
      end
      PH_TYPE: begin
        crc_d = ncrc; type_d = ntype;
        if (ncnt >= 31'd4) begin
          cnt_d = '0;
          if (f && ntype != TypeIhdr) begin
            emit = 1'b1;
            res_d = '{event_kind: EV_NOT_IHDR, chunk_type: ntype, chunk_length: l,
                      stored_crc: '0, computed_crc: '0, image_width: w, image_height: h,
                      sample_depth: hd[39:32], colour_code: hd[31:24],
                      compression_method: hd[23:16], filter_method: hd[15:8],
                      interlace_method: hd[7:0]};
            phase_d = PH_HALT;
          end else begin
            scrc_d = '0;
            phase_d = (l != '0) ? PH_DATA : PH_CRC;
          end
        end else begin
          cnt_d = ncnt;
        end
      end
      PH_DATA: begin
        crc_d = ncrc;
        if (t == TypeIhdr) begin
          case (c)
            31'd0:  wid_d[31:24] = b;
            31'd1:  wid_d[23:16] = b;
            31'd2:  wid_d[15:8]  = b;
            31'd3:  wid_d[7:0]   = b;
            31'd4:  hgt_d[31:24] = b;
            31'd5:  hgt_d[23:16] = b;
            31'd6:  hgt_d[15:8]  = b;
            31'd7:  hgt_d[7:0]   = b;
            31'd8:  hdr_d[39:32] = b;
            31'd9:  hdr_d[31:24] = b;
            31'd10: hdr_d[23:16] = b;
            31'd11: hdr_d[15:8]  = b;
            31'd12: hdr_d[7:0]   = b;
            default: ;
          endcase
        end
        if (ncnt >= l) begin
          cnt_d = '0; phase_d = PH_CRC;
        end else begin
          cnt_d = ncnt;
        end
      end
      PH_CRC: begin
        scrc_d = nscrc;
        if (ncnt < 31'd4) begin
          cnt_d = ncnt;
        end else begin
          emit = 1'b1;
          res_d = '{event_kind: (t == TypeIend) ? EV_IEND : EV_CHUNK, chunk_type: t,
                    chunk_length: l, stored_crc: nscrc, computed_crc: ~cr,
                    image_width: w, image_height: h,
                    sample_depth: hd[39:32], colour_code: hd[31:24],
                    compression_method: hd[23:16], filter_method: hd[15:8],
                    interlace_method: hd[7:0]};
          cnt_d = '0; first_d = 1'b0; len_d = '0; scrc_d = '0; crc_d = CrcInit;
          phase_d = (t == TypeIend) ? PH_HALT : PH_LEN;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SIG; cnt_q <= '0; len_q <= '0; type_q <= '0; crc_q <= CrcInit;
      scrc_q <= '0; wid_q <= '0; hgt_q <= '0; hdr_q <= '0; first_q <= 1'b1;
      res_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q <= phase_d; cnt_q <= cnt_d; len_q <= len_d; type_q <= type_d;
        crc_q <= crc_d; scrc_q <= scrc_d; wid_q <= wid_d; hgt_q <= hgt_d;
        hdr_q <= hdr_d; first_q <= first_d;
      end
      if (can_take) res_vld_q <= pop_o && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && emit) res_q <= res_d;
  end

  `include "png_chunk_stream_parser_macros.svh"
  `PCP_ASSERT_IMP(a_stall_hold, clk_i, rst_ni, res_vld_q && !out_if.ready, !pop_o, "pop while result stalled")
  `PCP_ASSERT_NEXT(a_emit_valid, clk_i, rst_ni, pop_o && emit, res_vld_q, "result lost")
  `PCP_ASSERT_IMP(a_cnt_sig, clk_i, rst_ni, phase_q == PH_SIG, cnt_q < 31'd8, "signature count range")
endmodule

@@ tb/sv/png_chunk_stream_parser_checker.sv @@
`timescale 1ns / 1ps

module png_chunk_stream_parser_checker (
  input  logic clk_i,
  input  logic rst_ni,
  pcsp_in_if   in_mon,
  pcsp_out_if  out_mon,
  output int   fail_count_o,
  output int   pending_o
);
  import pcsp_pkg::*;

  typedef enum logic [2:0] {
    PH_SIG, PH_LEN, PH_TYPE, PH_DATA, PH_CRC, PH_HALT
  } phase_e;

  phase_e      phase;
  logic [30:0] byte_cnt;
  logic [30:0] cur_len;
  logic [31:0] cur_type;
  logic [31:0] crc_acc;
  logic [31:0] crc_word;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic [39:0] hdr_bytes;
  logic        first_pending;

  out_item_t   chunk_reports[$];
  int          fails;

  assign fail_count_o = fails;

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 32'hedb88320) : (c >> 1);
    return (crc >> 8) ^ c;
  endfunction

  function automatic logic [7:0] magic(input logic [2:0] i);
    logic [7:0] t [8];
    t = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
    return t[i];
  endfunction

  function automatic void clear_state();
    phase = PH_SIG; byte_cnt = '0; cur_len = '0; cur_type = '0;
    crc_acc = '1; crc_word = '0; img_w = '0; img_h = '0;
    hdr_bytes = '0; first_pending = 1'b1;
  endfunction

  function automatic void report(input event_kind_e k, input logic [31:0] t,
                                 input logic [30:0] l, input logic [31:0] s,
                                 input logic [31:0] c);
    out_item_t r;
    r.event_kind = k; r.chunk_type = t; r.chunk_length = l;
    r.stored_crc = s; r.computed_crc = c; r.image_width = img_w;
    r.image_height = img_h; r.sample_depth = hdr_bytes[39:32];
    r.colour_code = hdr_bytes[31:24]; r.compression_method = hdr_bytes[23:16];
    r.filter_method = hdr_bytes[15:8]; r.interlace_method = hdr_bytes[7:0];
    chunk_reports.push_back(r);
  endfunction

  function automatic void parse_byte(input in_item_t it);
    logic [7:0] b;
    int idx;
    b = it.data_byte;
    if (it.start_of_file) clear_state();
    case (phase)
      PH_SIG: begin
        if (b != magic(byte_cnt[2:0])) begin
          report(EV_BAD_SIG, '0, '0, '0, '0);
          phase = PH_HALT;
        end else begin
          byte_cnt++;
          if (byte_cnt >= 8) begin
            byte_cnt = '0; phase = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        cur_len = {cur_len[22:0], b};
        byte_cnt++;
        if (byte_cnt >= 4) begin
          byte_cnt = '0; cur_type = '0; crc_acc = '1; phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        crc_acc = crc_step(crc_acc, b);
        cur_type = {cur_type[23:0], b};
        byte_cnt++;
        if (byte_cnt >= 4) begin
          byte_cnt = '0;
          if (first_pending && cur_type != TypeIhdr) begin
            report(EV_NOT_IHDR, cur_type, cur_len, '0, '0);
            phase = PH_HALT;
          end else begin
            crc_word = '0;
            phase = (cur_len != 0) ? PH_DATA : PH_CRC;
          end
        end
      end
      PH_DATA: begin
        crc_acc = crc_step(crc_acc, b);
        if (cur_type == TypeIhdr) begin
          idx = int'(byte_cnt);
          if (idx < 4) img_w[8*(3-idx) +: 8] = b;
          else if (idx < 8) img_h[8*(7-idx) +: 8] = b;
          else if (idx < 13) hdr_bytes[8*(12-idx) +: 8] = b;
        end
        byte_cnt++;
        if (byte_cnt >= cur_len) begin
          byte_cnt = '0; phase = PH_CRC;
        end
      end
      PH_CRC: begin
        crc_word = {crc_word[23:0], b};
        byte_cnt++;
        if (byte_cnt >= 4) begin
          report((cur_type == TypeIend) ? EV_IEND : EV_CHUNK, cur_type, cur_len,
                 crc_word, ~crc_acc);
          phase = (cur_type == TypeIend) ? PH_HALT : PH_LEN;
          byte_cnt = '0; first_pending = 1'b0; cur_len = '0;
          crc_word = '0; crc_acc = '1;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic cmp(input string f, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $error("%s: expected %h actual %h", f, e, a);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t e, a;
    if (!rst_ni) begin
      clear_state();
      chunk_reports.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        a = out_mon.payload;
        if (chunk_reports.size() == 0) begin
          $error("unexpected transaction: event_kind %0d", a.event_kind);
          fails++;
        end else begin
          e = chunk_reports.pop_front();
          cmp("event_kind", 32'(e.event_kind), 32'(a.event_kind));
          cmp("chunk_type", e.chunk_type, a.chunk_type);
          cmp("chunk_length", 32'(e.chunk_length), 32'(a.chunk_length));
          cmp("stored_crc", e.stored_crc, a.stored_crc);
          cmp("computed_crc", e.computed_crc, a.computed_crc);
          cmp("image_width", e.image_width, a.image_width);
          cmp("image_height", e.image_height, a.image_height);
          cmp("sample_depth", 32'(e.sample_depth), 32'(a.sample_depth));
          cmp("colour_code", 32'(e.colour_code), 32'(a.colour_code));
          cmp("compression_method", 32'(e.compression_method),
              32'(a.compression_method));
          cmp("filter_method", 32'(e.filter_method), 32'(a.filter_method));
          cmp("interlace_method", 32'(e.interlace_method), 32'(a.interlace_method));
        end
      end
      if (in_mon.valid && in_mon.ready) parse_byte(in_mon.payload);
    end
    pending_o <= chunk_reports.size();
  end

  initial fails = 0;
endmodule

@@ tb/sv/png_chunk_stream_parser_test.sv @@
`timescale 1ns / 1ps

module png_chunk_stream_parser_test;
  import pcsp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count;
  int   pending;
  int   send_idle = 6;
  int   recv_idle = 63;
  bit   hold_off = 1'b0;

  pcsp_in_if  in_if ();
  pcsp_out_if out_if ();

  png_chunk_stream_parser u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source)
  );

  png_chunk_stream_parser_checker u_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  in_item_t byte_stream[$];

  initial begin
    in_if.valid   = 1'b0;
    in_if.payload = '0;
  end

  initial out_if.ready = 1'b0;

  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) out_if.ready <= 1'b0;
    else out_if.ready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic void put(input logic [7:0] b, input bit sof = 1'b0);
    byte_stream.push_back('{data_byte: b, start_of_file: sof});
  endfunction

  function automatic void put_word(input logic [31:0] w);
    for (int i = 3; i >= 0; i--) put(w[8*i +: 8]);
  endfunction

  function automatic void put_magic();
    logic [7:0] t [8];
    t = '{8'd137, 8'd80, 8'd78, 8'd71, 8'd13, 8'd10, 8'd26, 8'd10};
    foreach (t[i]) put(t[i], i == 0);
  endfunction

  function automatic logic [31:0] rand_word();
    return $urandom;
  endfunction

  function automatic void put_chunk(input logic [31:0] t, input int len,
                                    input logic [31:0] lword, input bit good_crc);
    logic [31:0] c;
    logic [7:0]  b;
    c = '1;
    put_word(lword);
    for (int i = 3; i >= 0; i--) c = crc_update(c, t[8*i +: 8]);
    put_word(t);
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      c = crc_update(c, b);
      put(b);
    end
    put_word(good_crc ? ~c : rand_word());
  endfunction

  function automatic void put_file(input int n_chunks);
    int len;
    put_magic();
    put_chunk(TypeIhdr, 13, 32'd13, 1'($urandom_range(1)));
    for (int k = 0; k < n_chunks; k++) begin
      len = ($urandom_range(9) == 0) ? 0 : $urandom_range(20);
      case ($urandom_range(5))
        0: put_chunk(TypeIhdr, len, len, 1'b1);
        1: put_chunk(rand_word(), len, {1'b1, 31'(len)}, 1'b1);
        default: put_chunk(rand_word(), len, len, 1'($urandom_range(1)));
      endcase
    end
    if ($urandom_range(3) != 0) put_chunk(TypeIend, 0, 32'd0, 1'b1);
  endfunction

  task automatic send_all();
    while (byte_stream.size() > 0) begin
      if ($urandom_range(99) < send_idle) begin
        in_if.valid <= 1'b0;
        @(posedge clk_i);
      end else begin
        in_if.valid   <= 1'b1;
        in_if.payload <= byte_stream.pop_front();
        @(posedge clk_i);
        while (!in_if.ready) @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b0;
  endtask

  task automatic drain();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put(8'd0, 1'b1);
    put(8'hFF, 1'b1);
    put(8'd137, 1'b1); put(8'd80); put(8'd78); put(8'd72);
    put(8'd5);
    put_magic(); put_chunk(32'h49444154, 0, 32'd0, 1'b1);
    put_magic();
    put_chunk(TypeIhdr, 20, 32'd20, 1'b1);
    put_chunk(TypeIhdr, 5, 32'h80000005, 1'b0);
    put_chunk(TypeIend, 0, 32'd0, 1'b1);
    put(8'h00);
    send_all();
    drain();

    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 6 : (ph == 1) ? 63 : 0;
      recv_idle = (ph == 0) ? 63 : (ph == 1) ? 6 : 0;
      while (byte_stream.size() < 380) begin
        if ($urandom_range(7) == 0) put(8'($urandom), 1'b1);
        else if ($urandom_range(9) == 0) put(8'($urandom), 1'($urandom_range(1)));
        else put_file($urandom_range(4));
      end
      if (ph == 2) begin
        fork
          begin
            hold_off = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_off = 1'b0;
          end
          send_all();
        join
      end else begin
        send_all();
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("png_chunk_stream_parser_test: clean");
    end else begin
      $display("png_chunk_stream_parser_test: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("png_chunk_stream_parser_test: errors");
    $finish;
  end
endmodule
